FILE: rtl/f2d_pkg.sv
// shared types and constants for the four-state bits to decimal text block
package f2d_pkg;

  localparam int BITS_SEEN_W = 7;
  localparam logic [BITS_SEEN_W-1:0] BITS_SEEN_SAT = 7'd127;

  localparam logic [1:0] BIT_ZERO = 2'd0;
  localparam logic [1:0] BIT_ONE  = 2'd1;
  localparam logic [1:0] BIT_X    = 2'd2;
  localparam logic [1:0] BIT_Z    = 2'd3;

  localparam logic [6:0] CH_LOW_X  = 7'h78;
  localparam logic [6:0] CH_HIGH_X = 7'h58;
  localparam logic [6:0] CH_LOW_Z  = 7'h7a;
  localparam logic [6:0] CH_HIGH_Z = 7'h5a;
  localparam logic [6:0] CH_MINUS  = 7'h2d;
  localparam logic [6:0] CH_ZERO   = 7'h30;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LETTER,
    ST_SHIFT,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } f2d_state_t;

  // what the bit intake hands to the converter on the final beat
  typedef struct packed {
    logic       letter;
    logic [6:0] letter_char;
    logic       negative;
    logic       overflow;
  } f2d_summary_t;

endpackage

FILE: rtl/f2d_ifs.sv
// channel interfaces: bit input, text output and configuration write
interface f2d_bit_if;
  logic       valid;
  logic       ready;
  logic [1:0] bit_value;
  logic       last_bit;
  modport source (output valid, output bit_value, output last_bit, input ready);
  modport sink (input valid, input bit_value, input last_bit, output ready);
endinterface

interface f2d_text_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       last_char;
  logic       overflow;
  modport source (output valid, output char_code, output last_char, output overflow,
                  input ready);
  modport sink (input valid, input char_code, input last_char, input overflow,
                output ready);
endinterface

interface f2d_cfg_if;
  logic valid;
  logic ready;
  logic signed_mode;
  modport source (output valid, output signed_mode, input ready);
  modport sink (input valid, input signed_mode, output ready);
endinterface

FILE: rtl/f2d_acc.sv
// bit intake: sign handling, magnitude accumulation and x/z tracking
module f2d_acc #(
  parameter int MAX_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_data,
  input  logic                  beat,
  input  logic [1:0]            bit_value,
  input  logic                  last_bit,
  output logic                  start,
  output f2d_pkg::f2d_summary_t summary,
  output logic [MAX_BITS-1:0]   value
);

  localparam logic [f2d_pkg::BITS_SEEN_W-1:0] MAX_SEEN = f2d_pkg::BITS_SEEN_W'(MAX_BITS);

  logic                            signed_mode;
  logic [MAX_BITS-1:0]             magnitude;
  logic [f2d_pkg::BITS_SEEN_W-1:0] bits_seen;
  logic                            negative;
  logic                            any_unknown;
  logic                            all_unknown;
  logic                            any_floating;
  logic                            all_floating;

  logic [MAX_BITS-1:0]             magnitude_next;
  logic [f2d_pkg::BITS_SEEN_W-1:0] bits_seen_next;
  logic                            negative_next;
  logic                            any_unknown_next;
  logic                            all_unknown_next;
  logic                            any_floating_next;
  logic                            all_floating_next;
  logic                            is_sign;
  logic                            add;

  always_comb begin
    is_sign           = signed_mode && (bits_seen == '0);
    any_unknown_next  = any_unknown | (bit_value == f2d_pkg::BIT_X);
    all_unknown_next  = all_unknown & (bit_value == f2d_pkg::BIT_X);
    any_floating_next = any_floating | (bit_value == f2d_pkg::BIT_Z);
    all_floating_next = all_floating & (bit_value == f2d_pkg::BIT_Z);
    negative_next     = negative | (is_sign && (bit_value == f2d_pkg::BIT_ONE));
    // negative vectors collect inverted bits, plus one at the end
    add = negative ? (bit_value == f2d_pkg::BIT_ZERO) : (bit_value == f2d_pkg::BIT_ONE);
    if (is_sign) begin
      magnitude_next = magnitude;
    end else begin
      magnitude_next = (magnitude << 1) | MAX_BITS'(add);
    end
    if (bits_seen == f2d_pkg::BITS_SEEN_SAT) begin
      bits_seen_next = bits_seen;
    end else begin
      bits_seen_next = bits_seen + 1'b1;
    end
  end

  always_comb begin
    start                = beat && last_bit;
    value                = magnitude_next + MAX_BITS'(negative_next);
    summary.negative     = negative_next;
    summary.overflow     = bits_seen_next > MAX_SEEN;
    summary.letter       = any_unknown_next | any_floating_next;
    if (all_unknown_next) begin
      summary.letter_char = f2d_pkg::CH_LOW_X;
    end else if (any_unknown_next) begin
      summary.letter_char = f2d_pkg::CH_HIGH_X;
    end else if (all_floating_next) begin
      summary.letter_char = f2d_pkg::CH_LOW_Z;
    end else begin
      summary.letter_char = f2d_pkg::CH_HIGH_Z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode <= 1'b0;
    end else if (cfg_we) begin
      signed_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || start) begin
      magnitude    <= '0;
      bits_seen    <= '0;
      negative     <= 1'b0;
      any_unknown  <= 1'b0;
      all_unknown  <= 1'b1;
      any_floating <= 1'b0;
      all_floating <= 1'b1;
    end else if (beat) begin
      magnitude    <= magnitude_next;
      bits_seen    <= bits_seen_next;
      negative     <= negative_next;
      any_unknown  <= any_unknown_next;
      all_unknown  <= all_unknown_next;
      any_floating <= any_floating_next;
      all_floating <= all_floating_next;
    end
  end

endmodule

FILE: rtl/f2d_bcd_step.sv
// one double-dabble step: add three to every digit above four, then shift a bit in
module f2d_bcd_step #(
  parameter int NDIG = 20
) (
  input  logic [NDIG-1:0][3:0] bcd,
  input  logic                 bit_in,
  output logic [NDIG-1:0][3:0] bcd_next
);

  logic [NDIG-1:0][3:0] adj;
  logic [NDIG*4:0]      shifted;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i] = (bcd[i] > 4'd4) ? bcd[i] + 4'd3 : bcd[i];
    end
    shifted  = {adj, bit_in};
    bcd_next = shifted[NDIG*4-1:0];
  end

endmodule

FILE: rtl/f2d_conv.sv
// converter: shared bcd shift unit under a sequencer, plus the text output register
module f2d_conv #(
  parameter int MAX_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  f2d_pkg::f2d_summary_t summary,
  input  logic [MAX_BITS-1:0]   value,
  output logic                  busy,
  f2d_text_if.source            text
);

  localparam int NDIG  = (MAX_BITS * 30103) / 100000 + 1;
  localparam int CNT_W = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
  localparam int IDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_BITS - 1);
  localparam logic [IDX_W-1:0] TOP_IDX  = IDX_W'(NDIG - 1);

  f2d_pkg::f2d_state_t state, state_next;

  logic [MAX_BITS-1:0]  bin;
  logic [NDIG-1:0][3:0] bcd;
  logic [NDIG-1:0][3:0] bcd_next;
  logic [CNT_W-1:0]     cnt;
  logic [IDX_W-1:0]     idx;
  logic                 negative;
  logic                 overflow;
  logic [6:0]           letter_char;
  logic [3:0]           digit;
  logic                 out_free;
  logic                 shift_en;
  logic                 idx_dec;
  logic                 load_out;
  logic [6:0]           char_next;
  logic                 last_next;

  f2d_bcd_step #(.NDIG(NDIG)) u_step (
    .bcd      (bcd),
    .bit_in   (bin[MAX_BITS-1]),
    .bcd_next (bcd_next)
  );

  assign digit    = bcd[idx];
  assign out_free = !text.valid || text.ready;
  assign busy     = (state != f2d_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      f2d_pkg::ST_IDLE: begin
        if (start) state_next = summary.letter ? f2d_pkg::ST_LETTER : f2d_pkg::ST_SHIFT;
      end
      f2d_pkg::ST_LETTER: begin
        if (out_free) state_next = f2d_pkg::ST_IDLE;
      end
      f2d_pkg::ST_SHIFT: begin
        if (cnt == LAST_CNT) state_next = f2d_pkg::ST_SKIP;
      end
      f2d_pkg::ST_SKIP: begin
        if (digit != 4'd0 || idx == '0) begin
          state_next = negative ? f2d_pkg::ST_SIGN : f2d_pkg::ST_DIGIT;
        end
      end
      f2d_pkg::ST_SIGN: begin
        if (out_free) state_next = f2d_pkg::ST_DIGIT;
      end
      f2d_pkg::ST_DIGIT: begin
        if (out_free && idx == '0) state_next = f2d_pkg::ST_IDLE;
      end
      default: state_next = f2d_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    shift_en  = 1'b0;
    idx_dec   = 1'b0;
    load_out  = 1'b0;
    char_next = f2d_pkg::CH_ZERO + {3'b000, digit};
    last_next = 1'b1;
    case (state)
      f2d_pkg::ST_LETTER: begin
        load_out  = out_free;
        char_next = letter_char;
      end
      f2d_pkg::ST_SHIFT: begin
        shift_en = 1'b1;
      end
      f2d_pkg::ST_SKIP: begin
        // leading zeros, keeping the units digit
        idx_dec = (digit == 4'd0) && (idx != '0);
      end
      f2d_pkg::ST_SIGN: begin
        load_out  = out_free;
        char_next = f2d_pkg::CH_MINUS;
        last_next = 1'b0;
      end
      f2d_pkg::ST_DIGIT: begin
        load_out  = out_free;
        idx_dec   = out_free && (idx != '0);
        last_next = (idx == '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= f2d_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == f2d_pkg::ST_IDLE && start) begin
      bin         <= value;
      bcd         <= '0;
      cnt         <= '0;
      idx         <= TOP_IDX;
      negative    <= summary.negative;
      overflow    <= summary.overflow;
      letter_char <= summary.letter_char;
    end else begin
      if (shift_en) begin
        bin <= bin << 1;
        bcd <= bcd_next;
        cnt <= cnt + 1'b1;
      end
      if (idx_dec) begin
        idx <= idx - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text.valid <= 1'b0;
    end else if (load_out) begin
      text.valid <= 1'b1;
    end else if (text.ready) begin
      text.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      text.char_code <= char_next;
      text.last_char <= last_next;
      text.overflow  <= overflow;
    end
  end

endmodule

FILE: rtl/four_state_bits_to_decimal_text_top.sv
// top level: four-state bit stream to decimal ascii text
//
//  channel | dir | fields                          | beat when
//  bits    | in  | bit_value, last_bit             | valid & ready
//  text    | out | char_code, last_char, overflow  | valid & ready
//  cfg     | in  | signed_mode                     | valid & ready (ready tied high)
//
// one bit beat per cycle while no conversion runs
// the final bit starts the converter: a letter goes straight to the output register; a number
// is shifted bit by bit through the shared bcd shift unit, leading zeros are then skipped down
// to the units digit, and then the characters go out one at a time
// bits stay blocked until the last character sits in the output register
// text stalls hold the output register and the sequencer's output states; rst is synchronous
module four_state_bits_to_decimal_text_top #(
  parameter int MAX_BITS = 64
) (
  input  logic      clk,
  input  logic      rst,
  f2d_bit_if.sink   bits,
  f2d_text_if.source text,
  f2d_cfg_if.sink   cfg
);

  f2d_pkg::f2d_summary_t summary;
  logic [MAX_BITS-1:0]   value;
  logic                  start;
  logic                  busy;
  logic                  beat;

  assign bits.ready = !busy;
  assign cfg.ready  = 1'b1;
  assign beat       = bits.valid && bits.ready;

  f2d_acc #(.MAX_BITS(MAX_BITS)) u_acc (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg.valid && cfg.ready),
    .cfg_data  (cfg.signed_mode),
    .beat      (beat),
    .bit_value (bits.bit_value),
    .last_bit  (bits.last_bit),
    .start     (start),
    .summary   (summary),
    .value     (value)
  );

  f2d_conv #(.MAX_BITS(MAX_BITS)) u_conv (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .summary (summary),
    .value   (value),
    .busy    (busy),
    .text    (text)
  );

endmodule

FILE: rtl/f2d_checker.sv
// port-level checks for the top level, attached by bind
module f2d_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] out_char,
  input logic       out_last
);

  // the final bit always starts a conversion that blocks further bits
  a_block_after_last: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_last) |=> !in_ready)
    else $error("bits still taken after final bit");

  // nothing leaves the block in the cycle after reset
  a_quiet_after_rst: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("text beat right after reset");

  // letters stand alone, a minus sign never ends the text
  a_letter_alone: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_char == f2d_pkg::CH_LOW_X || out_char == f2d_pkg::CH_HIGH_X ||
                   out_char == f2d_pkg::CH_LOW_Z || out_char == f2d_pkg::CH_HIGH_Z))
    |-> out_last)
    else $error("x/z letter not final");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_char == f2d_pkg::CH_MINUS) |-> !out_last)
    else $error("minus sign marked final");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_char) && $stable(out_last)))
    else $error("stalled text beat changed");

endmodule

bind four_state_bits_to_decimal_text_top f2d_checker u_f2d_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (bits.valid),
  .in_ready  (bits.ready),
  .in_last   (bits.last_bit),
  .out_valid (text.valid),
  .out_ready (text.ready),
  .out_char  (text.char_code),
  .out_last  (text.last_char)
);
